/* rtl/assert_macros.svh */
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is high.
`define B64E_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define B64E_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/b64e_pkg.sv */
// Shared types, constants and the character map of the base64url stream encoder.
`timescale 1ns / 1ps

package b64e_pkg;

   // Widths fixed by the field definitions
   localparam int BYTE_W  = 8;
   localparam int LIMIT_W = 12;
   localparam int GROUP_W = 24;

   // Hard ceiling on the per-message character count
   localparam int MAX_LIMIT = 4095;

   // Default depth of the command queue between front and back
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Output limit after reset
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd63;

   // One unit of work for the back end: a group to encode or an overflow marker
   typedef struct packed {
      logic [GROUP_W-1:0] group;
      logic [1:0]         last_idx;  // index of the final result of this command
      logic               is_last;   // command closes the message
      logic               is_ovf;    // command is an overflow result
   } cmd_type;

   // Map a sextet to its URL-safe base64 character
   function automatic logic [7:0] b64e_char(input logic [5:0] sextet);
      logic [7:0] s;
      s = {2'b00, sextet};
      if (sextet < 6'd26) begin
         return 8'h41 + s;                // 'A'..'Z'
      end else if (sextet < 6'd52) begin
         return 8'h61 + (s - 8'd26);      // 'a'..'z'
      end else if (sextet < 6'd62) begin
         return 8'h30 + (s - 8'd52);      // '0'..'9'
      end else if (sextet == 6'd62) begin
         return 8'h2D;                    // '-'
      end else begin
         return 8'h5F;                    // '_'
      end
   endfunction

endpackage

/* rtl/b64e_front.sv */
// Front end: takes bytes, builds groups, counts against the limit, queues commands.
`timescale 1ns / 1ps

module b64e_front
   import b64e_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               req_final_byte,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_output_limit,
   input  logic               q_full,
   output logic               push,
   output cmd_type            push_cmd
);

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [15:0]        held_ff, held_in;
   logic [1:0]         fill_ff, fill_in;
   logic [LIMIT_W-1:0] chars_ff, chars_in;
   logic               disc_ff, disc_in;

   logic               accept;
   logic [LIMIT_W-1:0] limit_now;
   logic [GROUP_W-1:0] group;
   logic [1:0]         last_idx;
   logic [2:0]         n_chars;
   logic [LIMIT_W:0]   sum;
   logic               over;

   assign req_ready = ~q_full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid & req_ready;

   // Clamp the configured limit to the hard ceiling
   assign limit_now = (32'(limit_ff) > MAX_LIMIT) ? LIMIT_W'(MAX_LIMIT) : limit_ff;

   // Assemble the group around the incoming byte
   always_comb begin
      case (fill_ff)
         2'd0: begin
            group    = {req_data_byte, 16'h0000};
            last_idx = 2'd1;
            n_chars  = 3'd2;
         end
         2'd1: begin
            group    = {held_ff[15:8], req_data_byte, 8'h00};
            last_idx = 2'd2;
            n_chars  = 3'd3;
         end
         default: begin
            group    = {held_ff, req_data_byte};
            last_idx = 2'd3;
            n_chars  = 3'd4;
         end
      endcase
   end

   assign sum  = {1'b0, chars_ff} + (LIMIT_W + 1)'(n_chars);
   assign over = sum > {1'b0, limit_now};

   // Message state update and command issue
   always_comb begin
      held_in  = held_ff;
      fill_in  = fill_ff;
      chars_in = chars_ff;
      disc_in  = disc_ff;
      limit_in = (csr_valid & csr_ready) ? csr_output_limit : limit_ff;
      push     = 1'b0;
      push_cmd.group    = group;
      push_cmd.last_idx = last_idx;
      push_cmd.is_last  = req_final_byte;
      push_cmd.is_ovf   = 1'b0;
      if (accept) begin
         if (disc_ff) begin
            // drop bytes until the final one
            if (req_final_byte) begin
               disc_in  = 1'b0;
               held_in  = 16'h0000;
               fill_in  = 2'd0;
               chars_in = '0;
            end
         end else if (fill_ff != 2'd2 && !req_final_byte) begin
            // hold the byte for a later group
            if (fill_ff == 2'd0) begin
               held_in = {req_data_byte, 8'h00};
            end else begin
               held_in = {held_ff[15:8], req_data_byte};
            end
            fill_in = fill_ff + 2'd1;
         end else if (over) begin
            // abort the message with a single error result
            push              = 1'b1;
            push_cmd.last_idx = 2'd0;
            push_cmd.is_last  = 1'b1;
            push_cmd.is_ovf   = 1'b1;
            held_in           = 16'h0000;
            fill_in           = 2'd0;
            chars_in          = '0;
            disc_in           = ~req_final_byte;
         end else begin
            // issue the group for encoding
            push     = 1'b1;
            held_in  = 16'h0000;
            fill_in  = 2'd0;
            chars_in = req_final_byte ? '0 : sum[LIMIT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         held_ff  <= 16'h0000;
         fill_ff  <= 2'd0;
         chars_ff <= '0;
         disc_ff  <= 1'b0;
      end else begin
         limit_ff <= limit_in;
         held_ff  <= held_in;
         fill_ff  <= fill_in;
         chars_ff <= chars_in;
         disc_ff  <= disc_in;
      end
   end

endmodule

/* rtl/b64e_fifo.sv */
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module b64e_fifo
   import b64e_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type head_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_cmd  = slot_ff[rd_ptr_ff];
   assign do_push   = push & ~full;
   assign do_pop    = pop & not_empty;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the command payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/b64e_back.sv */
// Back end: expands queued commands into characters, one per cycle while rsp_ready allows, into the output register.
`timescale 1ns / 1ps

module b64e_back
   import b64e_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_not_empty,
   input  cmd_type           q_head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [BYTE_W-1:0] rsp_out_char,
   output logic              rsp_end_of_message,
   output logic              rsp_overflow
);

   logic              busy_ff, busy_in;
   cmd_type           cmd_ff, cmd_in;
   logic [1:0]        idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] char_ff, char_in;
   logic              eom_ff, eom_in;
   logic              ovf_ff, ovf_in;

   logic              out_free;
   logic              at_last;
   logic [5:0]        sextet;

   assign out_free = ~valid_ff | rsp_ready;
   assign at_last  = (idx_ff == cmd_ff.last_idx);
   assign pop      = q_not_empty & (~busy_ff | (out_free & at_last));

   // Pick the sextet for the current character
   always_comb begin
      case (idx_ff)
         2'd0:    sextet = cmd_ff.group[23:18];
         2'd1:    sextet = cmd_ff.group[17:12];
         2'd2:    sextet = cmd_ff.group[11:6];
         default: sextet = cmd_ff.group[5:0];
      endcase
   end

   // Emit a character when the output register frees up; load the next command
   always_comb begin
      busy_in  = busy_ff;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      eom_in   = eom_ff;
      ovf_in   = ovf_ff;
      if (out_free) begin
         valid_in = busy_ff;
         if (busy_ff) begin
            char_in = cmd_ff.is_ovf ? 8'h00 : b64e_char(sextet);
            eom_in  = cmd_ff.is_last & at_last;
            ovf_in  = cmd_ff.is_ovf;
            idx_in  = idx_ff + 2'd1;
            if (at_last) begin
               busy_in = 1'b0;
            end
         end
      end
      if (pop) begin
         busy_in = 1'b1;
         cmd_in  = q_head;
         idx_in  = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      char_ff <= char_in;
      eom_ff  <= eom_in;
      ovf_ff  <= ovf_in;
   end

   assign rsp_valid          = valid_ff;
   assign rsp_out_char       = char_ff;
   assign rsp_end_of_message = eom_ff;
   assign rsp_overflow       = ovf_ff;

endmodule

/* rtl/base64url_stream_encoder_unit.sv */
// Top level of the base64url stream encoder: front end, command queue, back end.
`timescale 1ns / 1ps

// Usage
//   req_*  : one message byte per transfer; req_final_byte marks the last byte.
//   rsp_*  : one character per transfer; rsp_end_of_message on the last one of a
//            message; an overflow shows as a single result with out_char 0,
//            end_of_message 1 and overflow 1, after which the rest of the
//            message is dropped.
//   csr_*  : write of the per-message character limit; csr_ready is always high.
// Timing
//   A byte that completes a group reaches rsp through the command queue, the
//   back end's command register and the output register. req_ready stays high
//   while the command queue has room, so bytes go in one per cycle; the output
//   register sends one character per cycle while rsp_ready is high.
// Reset
//   Clears the queue, the message state and the output; the limit returns to 63.
// Stall
//   With rsp_ready low the result holds; the queue keeps taking bytes until it
//   is full, then req_ready drops.

module base64url_stream_encoder_unit
   import b64e_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               req_final_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_out_char,
   output logic               rsp_end_of_message,
   output logic               rsp_overflow,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [LIMIT_W-1:0] csr_output_limit
);

   logic    push, pop, q_full, q_not_empty;
   cmd_type push_cmd, head_cmd;

   b64e_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_output_limit (csr_output_limit),
      .q_full           (q_full),
      .push             (push),
      .push_cmd         (push_cmd)
   );

   b64e_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_not_empty),
      .head_cmd  (head_cmd)
   );

   b64e_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_not_empty        (q_not_empty),
      .q_head             (head_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_overflow       (rsp_overflow)
   );

endmodule

/* rtl/b64e_checker.sv */
// Port-level checks of the base64url stream encoder and their bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b64e_checker
   import b64e_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [BYTE_W-1:0] rsp_out_char,
   input logic              rsp_end_of_message,
   input logic              rsp_overflow
);

   logic              rsp_stall;
   logic [BYTE_W+1:0] rsp_payload;
   logic              ovf_form;
   logic              char_ok;

   // Collect the result view used by the checks
   assign rsp_stall   = rsp_valid && !rsp_ready;
   assign rsp_payload = {rsp_out_char, rsp_end_of_message, rsp_overflow};
   assign ovf_form    = rsp_end_of_message && (rsp_out_char == 8'h00);
   assign char_ok     = (rsp_out_char >= 8'h41 && rsp_out_char <= 8'h5A) ||
                        (rsp_out_char >= 8'h61 && rsp_out_char <= 8'h7A) ||
                        (rsp_out_char >= 8'h30 && rsp_out_char <= 8'h39) ||
                        rsp_out_char == 8'h2D || rsp_out_char == 8'h5F;

   // A stalled result holds until its transfer
   `B64E_ASSERT(a_rsp_hold, rsp_stall |=> rsp_valid && $stable(rsp_payload), "held result changed")

   // An overflow result closes its message and carries no character
   `B64E_ASSERT(a_ovf_shape, rsp_valid && rsp_overflow |-> ovf_form, "malformed overflow result")

   // Normal results carry a URL-safe base64 character
   `B64E_ASSERT(a_alphabet, rsp_valid && !rsp_overflow |-> char_ok, "character outside the alphabet")

   // Reset leaves no result pending
   `B64E_ASSERT_ALWAYS(a_reset_empty, $past(reset) && !reset |-> !rsp_valid, "valid out of reset")

endmodule

bind base64url_stream_encoder_unit b64e_checker u_checker (.*);

/* bench/tb_base64url_stream_encoder_unit.sv */
// Self-checking testbench for the base64url stream encoder unit.
`timescale 1ns / 1ps

module tb_base64url_stream_encoder_unit;
   import b64e_pkg::*;

   // One character transfer as seen on the rsp channel
   typedef struct packed {
      logic [BYTE_W-1:0] out_char;
      logic              end_of_message;
      logic              overflow;
   } char_result_type;

   // Encoder predictor plus the queue of characters it still waits for
   class b64_scoreboard;
      logic [15:0]        held_bytes;
      logic [1:0]         group_fill;
      int unsigned        chars_emitted;
      bit                 dropping;
      logic [LIMIT_W-1:0] char_limit;
      char_result_type    char_q[$];
      int                 mismatches;
      int                 chars_checked;
      int                 overflows_seen;
      int                 messages_closed;
      string              alphabet;

      function new();
         alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
         char_limit = LIMIT_RESET;
         dropping = 0;
         clear_message();
      endfunction

      function void clear_message();
         held_bytes = '0;
         group_fill = '0;
         chars_emitted = 0;
      endfunction

      function int pending();
         return char_q.size();
      endfunction

      function void report(string what, char_result_type want, char_result_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: %s: expected %02h eom %0b ovf %0b, got %02h eom %0b ovf %0b",
               $time, what, want.out_char, want.end_of_message, want.overflow,
               got.out_char, got.end_of_message, got.overflow);
         end
      endfunction

      // Encode one accepted byte into the characters it should release
      function void note_byte(logic [7:0] data, logic last);
         logic [23:0]     group;
         int unsigned     count;
         char_result_type res;
         logic [5:0]      sextet;
         if (last) begin
            messages_closed++;
         end
         if (dropping) begin
            if (last) begin
               dropping = 0;
               clear_message();
            end
            return;
         end
         // Hold the first two bytes of a group
         if (group_fill < 2 && !last) begin
            if (group_fill == 0) begin
               held_bytes = {data, 8'h00};
            end else begin
               held_bytes[7:0] = data;
            end
            group_fill++;
            return;
         end
         case (group_fill)
            2'd0: begin
               group = {data, 16'h0000};
               count = 2;
            end
            2'd1: begin
               group = {held_bytes[15:8], data, 8'h00};
               count = 3;
            end
            default: begin
               group = {held_bytes, data};
               count = 4;
            end
         endcase
         // Abort the message when the group would pass the limit
         if (chars_emitted + count > char_limit) begin
            clear_message();
            dropping = !last;
            res.out_char = 8'h00;
            res.end_of_message = 1'b1;
            res.overflow = 1'b1;
            char_q.push_back(res);
            return;
         end
         for (int i = 0; i < count; i++) begin
            sextet = group[23 - 6 * i -: 6];
            res.out_char = alphabet[sextet];
            res.end_of_message = last && (i == count - 1);
            res.overflow = 1'b0;
            char_q.push_back(res);
         end
         chars_emitted = (chars_emitted + count) & 12'hFFF;
         held_bytes = '0;
         group_fill = '0;
         if (last) begin
            clear_message();
         end
      endfunction

      // Compare one transfer with the oldest expected character
      function void check_char(char_result_type got);
         char_result_type want;
         if (char_q.size() == 0) begin
            want = '0;
            report("character with none expected", want, got);
            return;
         end
         want = char_q.pop_front();
         chars_checked++;
         if (got.overflow === 1'b1) begin
            overflows_seen++;
         end
         if (got.out_char !== want.out_char || got.end_of_message !== want.end_of_message
               || got.overflow !== want.overflow) begin
            report("character mismatch", want, got);
         end
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [BYTE_W-1:0]  req_data_byte;
   logic               req_final_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [BYTE_W-1:0]  rsp_out_char;
   logic               rsp_end_of_message;
   logic               rsp_overflow;
   logic               csr_valid;
   logic               csr_ready;
   logic [LIMIT_W-1:0] csr_output_limit;

   b64_scoreboard sb;
   bit tx_burst;
   bit rx_burst;
   bit rsp_hold;
   bit pressure_go;
   int rsp_wait;
   int bytes_sent;

   base64url_stream_encoder_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_final_byte     (req_final_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_char       (rsp_out_char),
      .rsp_end_of_message (rsp_end_of_message),
      .rsp_overflow       (rsp_overflow),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_output_limit   (csr_output_limit)
   );

   // Generate the clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int draw_gap(bit burst);
      if (burst) begin
         return 0;
      end
      return $urandom_range(0, 10);
   endfunction

   // Check every character transfer and draw the next receiver stall
   always @(posedge clock) begin
      char_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.out_char = rsp_out_char;
         got.end_of_message = rsp_end_of_message;
         got.overflow = rsp_overflow;
         sb.check_char(got);
         rsp_wait = draw_gap(rx_burst);
      end
   end

   // Drive rsp_ready: count down the stall, honor the long hold-off
   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_wait--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold;
      end
   end

   // Hold off the receiver for a long stretch so the queue fills and req_ready drops
   initial begin
      wait (pressure_go);
      rsp_hold = 1'b1;
      repeat (80) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // Overall limit on the run
   initial begin
      #3000000;
      $display("tb_base64url_stream_encoder_unit failed");
      $finish;
   end

   // Offer one byte after a random gap and hold it until the transfer
   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      gap = draw_gap(tx_burst);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= data;
      req_final_byte <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(data, last);
      bytes_sent++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic send_random_message(input int len, input bit close);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), close && (i == len - 1));
      end
   endtask

   // Write the limit once every expected character is out and the back end has settled
   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      stop_sending();
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_output_limit <= value;
      do @(posedge clock); while (!csr_ready);
      sb.char_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int phase_limit[6];
      int phase_bytes;
      int len;
      sb = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = '0;
      req_final_byte = 1'b0;
      rsp_ready = 1'b0;
      csr_valid = 1'b0;
      csr_output_limit = '0;
      tx_burst = 1'b0;
      rx_burst = 1'b0;
      rsp_hold = 1'b0;
      pressure_go = 1'b0;
      rsp_wait = 0;
      bytes_sent = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: full group, one- and two-byte tails, top alphabet entries, reset limit
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h80, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFB, 1'b1);
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);
      // Zero limit: even a single byte overflows
      write_limit(12'd0);
      send_byte(8'h5A, 1'b1);
      // Overflow mid-message, then drop bytes up to the final one
      write_limit(12'd4);
      send_random_message(3, 1'b0);
      send_random_message(3, 1'b0);
      send_byte(8'hC3, 1'b1);
      // Group exactly at the limit, then overflow on the final tail
      send_random_message(3, 1'b0);
      send_byte(8'h01, 1'b1);
      // Lower the limit in the middle of a message
      write_limit(12'd63);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      write_limit(12'd2);
      send_byte(8'h56, 1'b1);

      // Random phases, each with its own limit
      phase_limit[0] = 4095;
      phase_limit[1] = $urandom_range(6, 24);
      phase_limit[2] = 63;
      phase_limit[3] = $urandom_range(0, 4095);
      phase_limit[4] = 1;
      phase_limit[5] = 4095;
      for (int p = 0; p < 6; p++) begin
         write_limit(LIMIT_W'(phase_limit[p]));
         tx_burst = (p == 2) || (p == 5);
         rx_burst = (p == 5);
         if (p == 2) begin
            pressure_go = 1'b1;
         end
         phase_bytes = 0;
         while (phase_bytes < 57) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            send_random_message(len, 1'b1);
            phase_bytes += len;
         end
         // Leave a message open across the limit change now and then
         if ($urandom_range(0, 2) == 0 && p < 5) begin
            send_random_message($urandom_range(1, 5), 1'b0);
         end
      end

      stop_sending();
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d bytes in %0d closed messages; checked %0d characters, %0d overflows.",
         bytes_sent, sb.messages_closed, sb.chars_checked, sb.overflows_seen);
      $display("Limits covered 0 through 4095 with stalls on both sides; mismatches: %0d.",
         sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb_base64url_stream_encoder_unit passed");
      end else begin
         $display("tb_base64url_stream_encoder_unit failed");
      end
      $finish;
   end

endmodule
